@@ src/assert_macros.svh @@
// assertion helpers for the checker file neec_check.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define NEEC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("neec assertion failed");

// next-cycle implication, masked while in reset
`define NEEC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("neec assertion failed");

// next-cycle implication that also watches the reset cycles
`define NEEC_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("neec reset assertion failed");

`endif

@@ src/neec_pkg.sv @@
`default_nettype none
package neec_pkg;

  localparam int unsigned MAX_ROWS_DEF    = 256;
  localparam int unsigned MAX_COLUMNS_DEF = 256;

  localparam int unsigned CFG_W = 9;
  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 9'd256;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic SIDE_LOWER = 1'b0;
  localparam logic SIDE_UPPER = 1'b1;

  typedef struct packed {
    logic [7:0] row_index;
    logic [7:0] column_index;
    logic       side;
    logic       last_of_run;
  } result_t;

endpackage
`default_nettype wire

@@ src/neec_ram.sv @@
`default_nettype none
module neec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/nearest_edge_each_side_of_center.sv @@
// channel   | direction | handshake          | payload
// in_       | input     | in_valid/in_stall   | in_cell_value
// out_      | output    | out_valid/out_stall | out_row_index, out_column_index,
//           |           |                     | out_side, out_last_of_run
// cfg (apb) | input     | psel/penable/pready | paddr, pwdata, prdata
//
// one cell per cycle unless in_stall; reports go through the modify stage and the queue.
// per-row state sits in a single-port-write, registered-read ram: read when the cell is
// taken, modified and written back the next cycle, with a one-entry forward for the same row.
// no clearing pass after reset: column 0 of every frame rewrites each row's entry.
// in_stall rises when the 8-entry result queue could not take two more reports;
// the middle-column cell may give two reports, so a long out_stall backs up into in_stall.
`default_nettype none
module nearest_edge_each_side_of_center #(
  parameter int unsigned MAX_ROWS    = neec_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = neec_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_cell_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_row_index,
  output logic [7:0]       out_column_index,
  output logic             out_side,
  output logic             out_last_of_run,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW       = $clog2(MAX_COLUMNS);
  localparam int unsigned SW       = CW + 2;
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam logic [12:0] MAX_ROWS_V = 13'(MAX_ROWS);
  localparam logic [12:0] MAX_COLS_V = 13'(MAX_COLUMNS);

  // configuration
  logic [neec_pkg::CFG_W-1:0] grid_width_r, grid_height_r;
  logic                       cfg_wr;
  neec_pkg::reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = neec_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= neec_pkg::GRID_WIDTH_RST;
      grid_height_r <= neec_pkg::GRID_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        neec_pkg::REG_GRID_WIDTH:  grid_width_r  <= pwdata[neec_pkg::CFG_W-1:0];
        neec_pkg::REG_GRID_HEIGHT: grid_height_r <= pwdata[neec_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      neec_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_r);
      neec_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_r);
      default:                   prdata = '0;
    endcase
  end

  // saturated grid size
  logic [12:0] w13, h13;
  logic [RW:0] eff_w;
  logic [CW:0] eff_h;
  logic [CW-1:0] mid;

  always_comb begin
    w13 = 13'(grid_width_r);
    if (w13 == 13'd0) begin
      w13 = 13'd1;
    end else if (w13 > MAX_ROWS_V) begin
      w13 = MAX_ROWS_V;
    end
    h13 = 13'(grid_height_r);
    if (h13 < 13'd2) begin
      h13 = 13'd2;
    end else if (h13 > MAX_COLS_V) begin
      h13 = MAX_COLS_V;
    end
  end

  assign eff_w = w13[RW:0];
  assign eff_h = h13[CW:0];
  assign mid   = eff_h[CW:1];

  // stream position
  logic          accept;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW:0]   row_inc;
  logic [CW:0]   col_inc;
  logic          row_wrap, col_wrap;

  assign accept   = in_valid & ~in_stall;
  assign row_inc  = (RW+1)'(row_r) + (RW+1)'(1);
  assign col_inc  = (CW+1)'(col_r) + (CW+1)'(1);
  assign row_wrap = row_inc >= eff_w;
  assign col_wrap = col_inc >= eff_h;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (row_wrap) begin
        row_nxt = '0;
        col_nxt = col_wrap ? '0 : col_inc[CW-1:0];
      end else begin
        row_nxt = row_inc[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // modify stage, fed while the ram read is in flight
  logic          s1_valid_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_edge_r, s1_clear_r, s1_le_r, s1_eq_r, s1_ge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_edge_r  <= in_cell_value != 8'd0;
      s1_clear_r <= col_r == '0;
      s1_le_r    <= col_r <= mid;
      s1_eq_r    <= col_r == mid;
      s1_ge_r    <= col_r >= mid;
    end
  end

  // row state word: {upper_found, lower_valid, lower_column}
  logic [SW-1:0] st_rd, st_cur, st_new;
  logic          fwd_valid_r;
  logic [RW-1:0] fwd_row_r;
  logic [SW-1:0] fwd_data_r;

  neec_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_ROWS)
  ) u_state (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_row_r),
    .wdata (st_new),
    .raddr (row_r),
    .rdata (st_rd)
  );

  // the write of the previous cell lands in the same cycle as this cell's read
  assign st_cur = (fwd_valid_r && fwd_row_r == s1_row_r) ? fwd_data_r : st_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_row_r  <= s1_row_r;
    fwd_data_r <= st_new;
  end

  logic          cur_uf, cur_lv, hit_low, new_lv, new_uf;
  logic [CW-1:0] cur_lc, new_lc;
  logic          rep_low, rep_up;
  logic [31:0]   row32, lc32, c32;
  logic [1:0]    npush;
  neec_pkg::result_t res0, res1;

  always_comb begin
    cur_uf  = st_cur[CW+1];
    cur_lv  = st_cur[CW];
    cur_lc  = st_cur[CW-1:0];
    hit_low = s1_edge_r & s1_le_r;
    new_lv  = cur_lv | hit_low;
    new_lc  = hit_low ? s1_col_r : cur_lc;
    rep_low = s1_valid_r & s1_eq_r & new_lv;
    rep_up  = s1_valid_r & s1_ge_r & s1_edge_r & ~cur_uf;
    new_uf  = cur_uf | rep_up;
    st_new  = {new_uf, new_lv, new_lc};
    if (s1_clear_r) begin
      st_new  = '0;
      rep_low = 1'b0;
      rep_up  = 1'b0;
    end

    row32 = 32'(s1_row_r);
    lc32  = 32'(new_lc);
    c32   = 32'(s1_col_r);

    res1.row_index    = row32[7:0];
    res1.column_index = c32[7:0];
    res1.side         = neec_pkg::SIDE_UPPER;
    res1.last_of_run  = 1'b1;

    if (rep_low) begin
      res0.row_index    = row32[7:0];
      res0.column_index = lc32[7:0];
      res0.side         = neec_pkg::SIDE_LOWER;
      res0.last_of_run  = ~rep_up;
    end else begin
      res0 = res1;
    end

    npush = {rep_low & rep_up, rep_low ^ rep_up};
  end

  // result queue
  neec_pkg::result_t oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  head_r, tail_r;
  logic [OQ_AW:0]    cnt_r;
  logic [OQ_AW+1:0]  need_w;
  logic              pop;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid & ~out_stall;

  // room for the cell in the modify stage and one more
  assign need_w   = (OQ_AW+2)'(cnt_r) + (s1_valid_r ? (OQ_AW+2)'(2) : (OQ_AW+2)'(0));
  assign in_stall = need_w > (OQ_AW+2)'(OQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      oq_r[tail_r] <= res0;
    end
    if (npush == 2'd2) begin
      oq_r[tail_r + OQ_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      tail_r <= tail_r + OQ_AW'(npush);
      head_r <= head_r + OQ_AW'(pop);
      cnt_r  <= cnt_r + (OQ_AW+1)'(npush) - (OQ_AW+1)'(pop);
    end
  end

  assign out_row_index    = oq_r[head_r].row_index;
  assign out_column_index = oq_r[head_r].column_index;
  assign out_side         = oq_r[head_r].side;
  assign out_last_of_run  = oq_r[head_r].last_of_run;

endmodule
`default_nettype wire

@@ src/neec_check.sv @@
`default_nettype none
`include "assert_macros.svh"
module neec_check (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_row_index,
  input wire logic [7:0] out_column_index,
  input wire logic       out_side,
  input wire logic       out_last_of_run
);

  logic [17:0] out_word;
  logic        pair_head;
  logic        upper_now;

  assign out_word  = {out_row_index, out_column_index, out_side, out_last_of_run};
  assign pair_head = out_valid && !out_last_of_run;
  assign upper_now = out_valid && out_side == neec_pkg::SIDE_UPPER;

  // a held transaction keeps its payload
  `NEEC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // the first of a pair is always the lower report
  `NEEC_ASSERT_IMP(a_pair_lower_first, pair_head, out_side == neec_pkg::SIDE_LOWER)

  // the upper report of a pair follows right behind, same row
  `NEEC_ASSERT_NXT(a_pair_upper_next, pair_head && !out_stall, upper_now && $stable(out_row_index))

  // reset empties the result queue
  `NEEC_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind nearest_edge_each_side_of_center neec_check u_neec_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_row_index    (out_row_index),
  .out_column_index (out_column_index),
  .out_side         (out_side),
  .out_last_of_run  (out_last_of_run)
);
`default_nettype wire
